[rtl/core/psd_pkg.sv]
// Package for the point-to-segment distance pipeline.
// Shared widths and constants; no dependencies.
package psd_pkg;

  localparam int CoordBitsDefault = 16;
  localparam int DistBits         = 17;
  localparam int QuotBits         = 17;
  localparam logic [DistBits-1:0] DistMax = '1;

endpackage

[rtl/core/psd_if.sv]
// Valid/ready channel interfaces for the distance pipeline: query beats in, distance beats out.
// Depends on psd_pkg.
interface psd_in_if #(
  parameter int COORD_BITS = psd_pkg::CoordBitsDefault
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_begin_x;
  logic signed [COORD_BITS-1:0] seg_begin_y;
  logic signed [COORD_BITS-1:0] seg_end_x;
  logic signed [COORD_BITS-1:0] seg_end_y;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;

  modport source (
    output valid, seg_begin_x, seg_begin_y, seg_end_x, seg_end_y, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, seg_begin_x, seg_begin_y, seg_end_x, seg_end_y, query_x, query_y,
    output ready
  );
endinterface

interface psd_out_if;
  logic                          valid;
  logic                          ready;
  logic [psd_pkg::DistBits-1:0]  distance;

  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

[rtl/core/point_segment_distance.sv]
// Point-to-segment distance, fully pipelined. One query beat can enter every clock unless
// the pipeline is full and its output is stalled. Each beat passes through one stage
// for coordinate differences, one for the twelve products, one for sums and the projection
// tests, COORD_BITS+1 stages of the three digit-by-digit square roots (one root bit each),
// one saturation check and 17 stages of restoring division (one quotient bit each), and the
// output register. Every stage carries its own valid bit and loads whenever it is empty or
// its successor moves, so bubbles collapse and a stalled output does not block entry until
// the pipeline is actually full. Depends on psd_pkg and psd_if.
module point_segment_distance #(
  parameter int COORD_BITS = psd_pkg::CoordBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  psd_in_if.sink     in_i,
  psd_out_if.source  out_o
);

  localparam int D   = COORD_BITS + 1;
  localparam int NW  = 2 * D;
  localparam int RB  = D;
  localparam int QB  = psd_pkg::QuotBits;
  localparam int MW  = (RB > QB) ? RB : QB;
  localparam int DW  = NW + QB + 1;
  localparam int SQ0 = 3;
  localparam int SS  = SQ0 + RB;
  localparam int DV0 = SS + 1;
  localparam int OS  = DV0 + QB;
  localparam int T   = OS + 1;

  // stage valid bits and load enables
  logic [T-1:0] v_q;
  logic [T-1:0] ld;
  logic [T-1:0] v_in;

  assign v_in = {v_q[T-2:0], in_i.valid};
  assign ld[T-1] = !v_q[T-1] || out_o.ready;
  for (genvar k = 0; k < T - 1; k++) begin : g_ld
    assign ld[k] = !v_q[k] || ld[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < T; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  assign in_i.ready = ld[0];

  // stage 0: differences
  logic signed [D-1:0] qbx_q, qby_q, qex_q, qey_q, ebx_q, eby_q, bex_q, bey_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      qbx_q <= {in_i.query_x[COORD_BITS-1], in_i.query_x}
             - {in_i.seg_begin_x[COORD_BITS-1], in_i.seg_begin_x};
      qby_q <= {in_i.query_y[COORD_BITS-1], in_i.query_y}
             - {in_i.seg_begin_y[COORD_BITS-1], in_i.seg_begin_y};
      qex_q <= {in_i.query_x[COORD_BITS-1], in_i.query_x}
             - {in_i.seg_end_x[COORD_BITS-1], in_i.seg_end_x};
      qey_q <= {in_i.query_y[COORD_BITS-1], in_i.query_y}
             - {in_i.seg_end_y[COORD_BITS-1], in_i.seg_end_y};
      ebx_q <= {in_i.seg_end_x[COORD_BITS-1], in_i.seg_end_x}
             - {in_i.seg_begin_x[COORD_BITS-1], in_i.seg_begin_x};
      eby_q <= {in_i.seg_end_y[COORD_BITS-1], in_i.seg_end_y}
             - {in_i.seg_begin_y[COORD_BITS-1], in_i.seg_begin_y};
      bex_q <= {in_i.seg_begin_x[COORD_BITS-1], in_i.seg_begin_x}
             - {in_i.seg_end_x[COORD_BITS-1], in_i.seg_end_x};
      bey_q <= {in_i.seg_begin_y[COORD_BITS-1], in_i.seg_begin_y}
             - {in_i.seg_end_y[COORD_BITS-1], in_i.seg_end_y};
    end
  end

  // stage 1: products
  logic signed [NW-1:0] sqbx_q, sqby_q, sqex_q, sqey_q, sebx_q, seby_q;
  logic signed [NW-1:0] d1a_q, d1b_q, d2a_q, d2b_q, c1_q, c2_q;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      sqbx_q <= qbx_q * qbx_q;
      sqby_q <= qby_q * qby_q;
      sqex_q <= qex_q * qex_q;
      sqey_q <= qey_q * qey_q;
      sebx_q <= ebx_q * ebx_q;
      seby_q <= eby_q * eby_q;
      d1a_q  <= qbx_q * ebx_q;
      d1b_q  <= qby_q * eby_q;
      d2a_q  <= qex_q * bex_q;
      d2b_q  <= qey_q * bey_q;
      c1_q   <= qbx_q * eby_q;
      c2_q   <= qby_q * ebx_q;
    end
  end

  // stage 2: sums of squares, cross magnitude, projection tests
  logic [NW-1:0] na_q, nb_q, nl_q, crs_q;
  logic          ok_q;
  logic [NW:0]   dot1, dot2, crx, crm;

  always_comb begin
    dot1 = {d1a_q[NW-1], d1a_q} + {d1b_q[NW-1], d1b_q};
    dot2 = {d2a_q[NW-1], d2a_q} + {d2b_q[NW-1], d2b_q};
    crx  = {c1_q[NW-1], c1_q} - {c2_q[NW-1], c2_q};
    crm  = crx[NW] ? (NW+1)'(0) - crx : crx;
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      na_q  <= NW'(sqbx_q + sqby_q);
      nb_q  <= NW'(sqex_q + sqey_q);
      nl_q  <= NW'(sebx_q + seby_q);
      crs_q <= crm[NW-1:0];
      ok_q  <= !dot1[NW] && !dot2[NW];
    end
  end

  // square-root stages: roots of [0] begin dist, [1] end dist, [2] segment length
  logic [RB-1:0] sr_q [RB][3];
  logic [NW-1:0] sm_q [RB][3];
  logic [NW-1:0] scr_q [RB];
  logic          sok_q [RB];

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam int I = RB - 1 - j;
    logic [RB-1:0] r_in  [3];
    logic [NW-1:0] m_in  [3];
    logic [RB-1:0] r_out [3];
    logic [NW-1:0] m_out [3];
    logic [NW-1:0] cr_in;
    logic          ok_in;

    if (j == 0) begin : g_first
      assign r_in[0] = '0;
      assign r_in[1] = '0;
      assign r_in[2] = '0;
      assign m_in[0] = na_q;
      assign m_in[1] = nb_q;
      assign m_in[2] = nl_q;
      assign cr_in   = crs_q;
      assign ok_in   = ok_q;
    end else begin : g_next
      assign r_in  = sr_q[j-1];
      assign m_in  = sm_q[j-1];
      assign cr_in = scr_q[j-1];
      assign ok_in = sok_q[j-1];
    end

    always_comb begin
      logic [NW:0] trial;
      for (int k = 0; k < 3; k++) begin
        trial = ((NW+1)'(r_in[k]) << (I + 1)) | ((NW+1)'(1) << (2 * I));
        if ({1'b0, m_in[k]} >= trial) begin
          r_out[k] = r_in[k] | (RB'(1) << I);
          m_out[k] = m_in[k] - trial[NW-1:0];
        end else begin
          r_out[k] = r_in[k];
          m_out[k] = m_in[k];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[SQ0+j]) begin
        sr_q[j]  <= r_out;
        sm_q[j]  <= m_out;
        scr_q[j] <= cr_in;
        sok_q[j] <= ok_in;
      end
    end
  end

  // saturation stage: endpoint minimum, overflow of the quotient
  logic [RB-1:0] ra, rb, rl, rmin;
  logic [MW-1:0] rmin_ext;
  logic [QB-1:0] xdm_q;
  logic [NW-1:0] xr_q;
  logic [RB-1:0] xd_q;
  logic          xuse_q, xsat_q;

  always_comb begin
    ra       = sr_q[RB-1][0];
    rb       = sr_q[RB-1][1];
    rl       = sr_q[RB-1][2];
    rmin     = (rb < ra) ? rb : ra;
    rmin_ext = MW'(rmin);
  end

  always_ff @(posedge clk_i) begin
    if (ld[SS]) begin
      xdm_q  <= (rmin_ext > MW'(psd_pkg::DistMax)) ? psd_pkg::DistMax : QB'(rmin_ext);
      xr_q   <= scr_q[RB-1];
      xd_q   <= rl;
      xuse_q <= sok_q[RB-1] && (rl != '0);
      xsat_q <= DW'(scr_q[RB-1]) >= (DW'(rl) << QB);
    end
  end

  // restoring division stages
  logic [NW-1:0] dr_q  [QB];
  logic [RB-1:0] dd_q  [QB];
  logic [QB-1:0] dq_q  [QB];
  logic [QB-1:0] ddm_q [QB];
  logic          duse_q [QB];
  logic          dsat_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int I = QB - 1 - j;
    logic [NW-1:0] r_in, r_out;
    logic [RB-1:0] d_in;
    logic [QB-1:0] q_in, q_out, dm_in;
    logic          use_in, sat_in;
    logic [DW-1:0] trial;

    if (j == 0) begin : g_first
      assign r_in   = xr_q;
      assign d_in   = xd_q;
      assign q_in   = '0;
      assign dm_in  = xdm_q;
      assign use_in = xuse_q;
      assign sat_in = xsat_q;
    end else begin : g_next
      assign r_in   = dr_q[j-1];
      assign d_in   = dd_q[j-1];
      assign q_in   = dq_q[j-1];
      assign dm_in  = ddm_q[j-1];
      assign use_in = duse_q[j-1];
      assign sat_in = dsat_q[j-1];
    end

    always_comb begin
      trial = DW'(d_in) << I;
      if (DW'(r_in) >= trial) begin
        r_out = r_in - trial[NW-1:0];
        q_out = q_in | (QB'(1) << I);
      end else begin
        r_out = r_in;
        q_out = q_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[DV0+j]) begin
        dr_q[j]   <= r_out;
        dd_q[j]   <= d_in;
        dq_q[j]   <= q_out;
        ddm_q[j]  <= dm_in;
        duse_q[j] <= use_in;
        dsat_q[j] <= sat_in;
      end
    end
  end

  // output register
  logic [QB-1:0] dist_q, dist_d, perp;

  always_comb begin
    perp = dsat_q[QB-1] ? psd_pkg::DistMax : dq_q[QB-1];
    if (duse_q[QB-1] && (perp < ddm_q[QB-1])) begin
      dist_d = perp;
    end else begin
      dist_d = ddm_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[OS]) begin
      dist_q <= dist_d;
    end
  end

  assign out_o.valid    = v_q[T-1];
  assign out_o.distance = dist_q;

endmodule
